/* sv/hex_text_to_integer_top_assert.svh */
// assertion macros for the hex text parser
`ifndef HEX_TEXT_TO_INTEGER_TOP_ASSERT_SVH
`define HEX_TEXT_TO_INTEGER_TOP_ASSERT_SVH

// condition in the same cycle
`define HEXINT_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// condition in the following cycle
`define HEXINT_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* sv/hexint_pkg.sv */
package hexint_pkg;

    // field widths
    localparam int CHAR_W   = 8;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 64;
    localparam int DIGIT_W  = 4;
    localparam int CFG_IDX_W = 8;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // character codes
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F  = 8'h46;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 8'd1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SYN   = 2'd3;

    // parse phase
    typedef enum logic [2:0] {
        PH_LEAD  = 3'd0,
        PH_SIGN  = 3'd1,
        PH_DIG   = 3'd2,
        PH_TRAIL = 3'd3
    } t_phase;

    // one classified character
    typedef struct packed {
        logic               end_mark;
        logic               blank;
        logic               plus;
        logic               minus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } t_item;

    // queue status seen by front, back and top
    typedef struct packed {
        logic               full;
        logic               empty;
        logic [FIFO_CW-1:0] count;
    } t_fifo_stat;

endpackage

/* sv/hexint_if.sv */
// input character request channel
interface hexint_in_if;
    logic                           valid;
    logic                           ready;
    logic [hexint_pkg::CHAR_W-1:0]  char_code;
    logic                           end_marker;

    modport source (output valid, output char_code, output end_marker, input ready);
    modport sink   (input valid, input char_code, input end_marker, output ready);
endinterface

// result request channel
interface hexint_out_if;
    logic                            valid;
    logic                            ready;
    logic [hexint_pkg::STATUS_W-1:0] status;
    logic [hexint_pkg::VALUE_W-1:0]  value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

// configuration write channel
interface hexint_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [hexint_pkg::CFG_IDX_W-1:0] index;
    logic                             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/hex_text_to_integer_top.sv */
// Hex text parser: takes one ASCII character per request and, on a request with end_marker
// set, returns one result (status and 64-bit value) for the string closed by it. It accepts
// one character every cycle without pause while results are taken; a closing request's
// result passes a classifier register, a four-entry queue and the result register before
// it is valid at the output. The rate is set by the parser step in the back end, which does
// the 4-bit shift, digit add and exact range compare of one character combinationally.
// A stalled result port holds only closing requests back; the queue keeps the input moving
// until it fills. Register writes (0 signed_mode, 1 wide_mode) are taken in any cycle, are
// meant for an idle block, and restart the string in progress.
`include "hex_text_to_integer_top_assert.svh"

module hex_text_to_integer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hexint_in_if.sink   i_in,
    hexint_cfg_if.sink  i_cfg,
    hexint_out_if.source o_out
);

    logic                    push;
    logic                    pop;
    hexint_pkg::t_item       front_item;
    hexint_pkg::t_item       queue_item;
    hexint_pkg::t_fifo_stat  fifo_stat;

    // character classifier
    hexint_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_fifo_stat (fifo_stat),
        .o_push      (push),
        .o_item      (front_item)
    );

    // queue between classifier and parser
    hexint_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_stat  (fifo_stat)
    );

    // parser and result register
    hexint_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_item      (queue_item),
        .i_fifo_stat (fifo_stat),
        .o_pop       (pop),
        .o_out       (o_out)
    );

    // checks
    `HEXINT_ASSERT_IMP(a_err_value_zero, i_clk, i_rst_n, o_out.valid && o_out.status != hexint_pkg::ST_OK, o_out.value == '0, "failed result with nonzero value")
    `HEXINT_ASSERT_IMP(a_no_push_when_full, i_clk, i_rst_n, push, !fifo_stat.full, "push into full queue")
    `HEXINT_ASSERT_IMP(a_no_pop_when_empty, i_clk, i_rst_n, pop, !fifo_stat.empty, "pop from empty queue")
    `HEXINT_ASSERT_NEXT(a_last_entry_drains, i_clk, i_rst_n, pop && !push && fifo_stat.count == hexint_pkg::FIFO_CW'(1), fifo_stat.empty, "queue not empty after last pop")

endmodule

/* sv/hexint_front.sv */
module hexint_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    hexint_in_if.sink               i_in,
    input  hexint_pkg::t_fifo_stat  i_fifo_stat,
    output logic                    o_push,
    output hexint_pkg::t_item       o_item
);

    logic              r_valid;
    hexint_pkg::t_item r_item;
    hexint_pkg::t_item n_item;
    logic              accept;

    // hand the held item to the queue when it has room
    assign o_push     = r_valid && !i_fifo_stat.full;
    assign o_item     = r_item;
    assign i_in.ready = !r_valid || !i_fifo_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // classify the incoming character
    always_comb begin
        logic [hexint_pkg::CHAR_W-1:0] c;
        c = i_in.char_code;
        n_item.end_mark = i_in.end_marker;
        n_item.blank    = (c == hexint_pkg::CH_BLANK);
        n_item.plus     = (c == hexint_pkg::CH_PLUS);
        n_item.minus    = (c == hexint_pkg::CH_MINUS);
        n_item.is_digit = 1'b1;
        n_item.digit    = '0;
        if (c >= hexint_pkg::CH_ZERO && c <= hexint_pkg::CH_NINE) begin
            n_item.digit = c[hexint_pkg::DIGIT_W-1:0];
        end else if (c >= hexint_pkg::CH_LO_A && c <= hexint_pkg::CH_LO_F) begin
            n_item.digit = c[hexint_pkg::DIGIT_W-1:0] + 4'd9;
        end else if (c >= hexint_pkg::CH_UP_A && c <= hexint_pkg::CH_UP_F) begin
            n_item.digit = c[hexint_pkg::DIGIT_W-1:0] + 4'd9;
        end else begin
            n_item.is_digit = 1'b0;
        end
    end

    // holding register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // holding register payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

/* sv/hexint_fifo.sv */
module hexint_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  hexint_pkg::t_item       i_item,
    input  logic                    i_pop,
    output hexint_pkg::t_item       o_item,
    output hexint_pkg::t_fifo_stat  o_stat
);

    hexint_pkg::t_item                  r_mem [hexint_pkg::FIFO_DEPTH];
    logic [hexint_pkg::FIFO_AW-1:0]     r_wr_ptr;
    logic [hexint_pkg::FIFO_AW-1:0]     r_rd_ptr;
    logic [hexint_pkg::FIFO_CW-1:0]     r_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_stat.full  = (r_count == hexint_pkg::FIFO_CW'(hexint_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.count = r_count;
    assign o_item       = r_mem[r_rd_ptr];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* sv/hexint_back.sv */
module hexint_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    hexint_cfg_if.sink              i_cfg,
    input  hexint_pkg::t_item       i_item,
    input  hexint_pkg::t_fifo_stat  i_fifo_stat,
    output logic                    o_pop,
    hexint_out_if.source            o_out
);

    localparam int ACC_W = hexint_pkg::VALUE_W;
    localparam int EXT_W = hexint_pkg::VALUE_W + hexint_pkg::DIGIT_W;

    logic                              r_signed_mode;
    logic                              r_wide_mode;
    hexint_pkg::t_phase                r_phase;
    hexint_pkg::t_phase                n_phase;
    logic [ACC_W-1:0]                  r_acc;
    logic [ACC_W-1:0]                  n_acc;
    logic                              r_neg;
    logic                              n_neg;
    logic [hexint_pkg::STATUS_W-1:0]   r_err;
    logic [hexint_pkg::STATUS_W-1:0]   n_err;
    logic                              r_out_valid;
    logic [hexint_pkg::STATUS_W-1:0]   r_status;
    logic [hexint_pkg::VALUE_W-1:0]    r_value;
    logic [hexint_pkg::VALUE_W-1:0]    n_value;
    logic                              cfg_write;
    logic                              emit;
    logic [ACC_W-1:0]                  limit;
    logic                              too_big;

    assign i_cfg.ready  = 1'b1;
    assign cfg_write    = i_cfg.valid && (i_cfg.index == hexint_pkg::CFG_SIGNED_MODE ||
                                          i_cfg.index == hexint_pkg::CFG_WIDE_MODE);
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.value  = r_value;

    // take the next item unless it closes a string and the result slot is busy
    assign o_pop = !i_fifo_stat.empty &&
                   (!i_item.end_mark || !r_out_valid || o_out.ready);
    assign emit  = o_pop && i_item.end_mark;

    // largest magnitude for the current mode and sign, then the exact range check
    always_comb begin
        logic [ACC_W-1:0] full;
        full = r_wide_mode ? {ACC_W{1'b1}} : {{(ACC_W/2){1'b0}}, {(ACC_W/2){1'b1}}};
        if (!r_signed_mode) begin
            limit = full;
        end else if (r_neg) begin
            limit = (full >> 1) + 1'b1;
        end else begin
            limit = full >> 1;
        end
        too_big = {r_acc, i_item.digit} > {{hexint_pkg::DIGIT_W{1'b0}}, limit};
    end

    // next state of the parser
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_err   = r_err;
        if (i_item.end_mark) begin
            n_phase = hexint_pkg::PH_LEAD;
            n_acc   = '0;
            n_neg   = 1'b0;
            n_err   = hexint_pkg::ST_OK;
        end else if (r_err == hexint_pkg::ST_OK) begin
            case (r_phase)
                hexint_pkg::PH_LEAD: begin
                    if (i_item.blank) begin
                        n_phase = hexint_pkg::PH_LEAD;
                    end else if (r_signed_mode && (i_item.plus || i_item.minus)) begin
                        n_neg   = i_item.minus;
                        n_phase = hexint_pkg::PH_SIGN;
                    end else if (i_item.is_digit) begin
                        if (too_big) begin
                            n_err = r_neg ? hexint_pkg::ST_UNDER : hexint_pkg::ST_OVER;
                        end else begin
                            n_acc   = {r_acc[ACC_W-hexint_pkg::DIGIT_W-1:0], i_item.digit};
                            n_phase = hexint_pkg::PH_DIG;
                        end
                    end else begin
                        n_err = hexint_pkg::ST_SYN;
                    end
                end
                hexint_pkg::PH_SIGN, hexint_pkg::PH_DIG: begin
                    if (i_item.blank) begin
                        if (r_phase == hexint_pkg::PH_DIG) begin
                            n_phase = hexint_pkg::PH_TRAIL;
                        end
                    end else if (i_item.is_digit) begin
                        if (too_big) begin
                            n_err = r_neg ? hexint_pkg::ST_UNDER : hexint_pkg::ST_OVER;
                        end else begin
                            n_acc   = {r_acc[ACC_W-hexint_pkg::DIGIT_W-1:0], i_item.digit};
                            n_phase = hexint_pkg::PH_DIG;
                        end
                    end else begin
                        n_err = hexint_pkg::ST_SYN;
                    end
                end
                default: begin
                    if (!i_item.blank) begin
                        n_err = hexint_pkg::ST_SYN;
                    end
                end
            endcase
        end
    end

    // result value for a closing item
    always_comb begin
        n_value = '0;
        if (r_err == hexint_pkg::ST_OK) begin
            n_value = r_neg ? (~r_acc + 1'b1) : r_acc;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b1;
            r_wide_mode   <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == hexint_pkg::CFG_SIGNED_MODE) begin
                r_signed_mode <= i_cfg.data;
            end
            if (i_cfg.index == hexint_pkg::CFG_WIDE_MODE) begin
                r_wide_mode <= i_cfg.data;
            end
        end
    end

    // parser state, cleared by a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_write) begin
            r_phase <= hexint_pkg::PH_LEAD;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_err   <= hexint_pkg::ST_OK;
        end else if (o_pop) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_err   <= n_err;
        end
    end

    // result slot valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result slot payload
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_status <= r_err;
            r_value  <= n_value;
        end
    end

endmodule

/* sim/hex_text_to_integer_checker.sv */
// watches the character, register and result channels, predicts each parse result
// and compares it with what the block returns
module hex_text_to_integer_checker
    import hexint_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    hexint_in_if  i_in,
    hexint_cfg_if i_cfg,
    hexint_out_if i_res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
    } t_parse_result;

    // results owed by closing requests already taken, oldest first
    t_parse_result       parse_results_q[$];

    // mirror of the parser and its registers
    logic                signed_mode;
    logic                wide_mode;
    t_phase              phase;
    logic [VALUE_W-1:0]  magnitude;
    logic                negative;
    logic [STATUS_W-1:0] first_error;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic note_failure(input t_parse_result want, input t_parse_result seen,
                                input bit unexpected);
        if (o_fail_count < 10) begin
            if (unexpected)
                $display("unexpected parse result: status %0d value %h",
                         seen.status, seen.value);
            else
                $display("parse result mismatch: expected status %0d value %h, got status %0d value %h",
                         want.status, want.value, seen.status, seen.value);
        end
        o_fail_count++;
    endtask

    task automatic clear_string();
        phase       = PH_LEAD;
        magnitude   = '0;
        negative    = 1'b0;
        first_error = ST_OK;
    endtask

    // largest magnitude the current mode and sign allow
    function automatic logic [VALUE_W-1:0] magnitude_limit();
        logic [VALUE_W-1:0] full;
        full = wide_mode ? '1 : 64'h0000_0000_FFFF_FFFF;
        if (!signed_mode)
            return full;
        return negative ? (full >> 1) + 1 : (full >> 1);
    endfunction

    function automatic logic hex_digit(input logic [CHAR_W-1:0] c,
                                       output logic [DIGIT_W-1:0] d);
        d = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
            return 1'b1;
        end
        if (c >= CH_LO_A && c <= CH_LO_F) begin
            d = DIGIT_W'(c - CH_LO_A + 8'd10);
            return 1'b1;
        end
        if (c >= CH_UP_A && c <= CH_UP_F) begin
            d = DIGIT_W'(c - CH_UP_A + 8'd10);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // exact range test before the shift and add
    task automatic add_digit(input logic [DIGIT_W-1:0] d);
        logic [VALUE_W-1:0] lim;
        lim = magnitude_limit();
        if (magnitude > ((lim - d) >> DIGIT_W)) begin
            first_error = negative ? ST_UNDER : ST_OVER;
        end else begin
            magnitude = (magnitude << DIGIT_W) + d;
            phase     = PH_DIG;
        end
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        logic               is_hex;
        logic               blank;
        is_hex = hex_digit(c, d);
        blank  = (c == CH_BLANK);
        // the first error of a string sticks
        if (first_error != ST_OK)
            return;
        case (phase)
            PH_LEAD: begin
                if (!blank) begin
                    if (signed_mode && (c == CH_PLUS || c == CH_MINUS)) begin
                        negative = (c == CH_MINUS);
                        phase    = PH_SIGN;
                    end else if (is_hex) begin
                        add_digit(d);
                    end else begin
                        first_error = ST_SYN;
                    end
                end
            end
            PH_SIGN, PH_DIG: begin
                if (blank) begin
                    if (phase == PH_DIG)
                        phase = PH_TRAIL;
                end else if (is_hex) begin
                    add_digit(d);
                end else begin
                    first_error = ST_SYN;
                end
            end
            default: begin
                if (!blank)
                    first_error = ST_SYN;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_parse_result seen;
        t_parse_result want;
        if (!i_rst_n) begin
            signed_mode = 1'b1;
            wide_mode   = 1'b0;
            clear_string();
            parse_results_q.delete();
        end else begin
            // result request against the oldest prediction
            if (i_res.valid && i_res.ready) begin
                seen.status = i_res.status;
                seen.value  = i_res.value;
                if (parse_results_q.size() == 0) begin
                    note_failure(seen, seen, 1'b1);
                end else begin
                    want = parse_results_q.pop_front();
                    if (want.status !== seen.status || want.value !== seen.value)
                        note_failure(want, seen, 1'b0);
                end
            end
            // register write, which also restarts the string
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == CFG_SIGNED_MODE) begin
                    signed_mode = i_cfg.data;
                    clear_string();
                end else if (i_cfg.index == CFG_WIDE_MODE) begin
                    wide_mode = i_cfg.data;
                    clear_string();
                end
            end
            // character request
            if (i_in.valid && i_in.ready) begin
                if (i_in.end_marker) begin
                    want.status = first_error;
                    want.value  = '0;
                    if (first_error == ST_OK)
                        want.value = negative ? '0 - magnitude : magnitude;
                    parse_results_q.push_back(want);
                    clear_string();
                end else begin
                    parse_char(i_in.char_code);
                end
            end
        end
        o_pending = parse_results_q.size();
    end

endmodule

/* sim/hex_text_to_integer_top_tb.sv */
// stimulus for the hex text parser: directed strings, then phases of random strings
// under every mode setting, with stalls on both sides
module hex_text_to_integer_top_tb;
    import hexint_pkg::*;

    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int PHASES          = 8;
    localparam int CHARS_PER_PHASE = 200;

    typedef logic [CHAR_W-1:0] t_text[$];

    logic i_clk;
    logic i_rst_n;

    int   fail_count;
    int   results_due;
    int   chars_sent;
    int   quiet_count;
    bit   quiet_tail;
    bit   hold_results;
    bit   mode_signed;
    bit   mode_wide;

    hexint_in_if  in_ch();
    hexint_cfg_if cfg_ch();
    hexint_out_if res_ch();

    hex_text_to_integer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (res_ch)
    );

    hex_text_to_integer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_cfg        (cfg_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (results_due)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // watchdog on cycles with no request taken anywhere
    initial quiet_count = 0;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
            (res_ch.valid && res_ch.ready)) begin
            quiet_count <= 0;
        end else if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("** hex_text_to_integer_top: FAILED **");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // result side: random stall bursts, and one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_results = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [CHAR_W-1:0] code, input logic closing);
        if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.char_code  <= code;
        in_ch.end_marker <= closing;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        chars_sent++;
    endtask

    task automatic send_chars(input t_text s, input bit closing);
        foreach (s[i])
            send_item(s[i], 1'b0);
        if (closing)
            send_item(CHAR_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string str);
        t_text s;
        for (int i = 0; i < str.len(); i++)
            s.push_back(str[i]);
        send_chars(s, 1'b1);
    endtask

    // stop sending and let every owed result and any stray character work through
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (results_due != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic bit_value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= bit_value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_modes(input bit signed_on, input bit wide_on);
        write_reg(CFG_SIGNED_MODE, signed_on);
        write_reg(CFG_WIDE_MODE, wide_on);
        mode_signed = signed_on;
        mode_wide   = wide_on;
    endtask

    // hex digit in a random letter case
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] nib);
        if (nib < 10)
            return CH_ZERO + nib;
        return ($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + nib - 8'd10;
    endfunction

    // value as hex text, sometimes with leading zeros
    function automatic t_text hex_digits(input logic [VALUE_W-1:0] v);
        t_text              s;
        logic [DIGIT_W-1:0] nib;
        bit                 started;
        started = 1'b0;
        repeat ($urandom_range(0, 2)) s.push_back(CH_ZERO);
        for (int i = VALUE_W / DIGIT_W - 1; i >= 0; i--) begin
            nib = v[i*DIGIT_W +: DIGIT_W];
            if (nib != 0 || started || i == 0) begin
                started = 1'b1;
                s.push_back(digit_char(nib));
            end
        end
        return s;
    endfunction

    // mostly well-formed text: blanks, optional sign, digits near the range edge or random
    function automatic t_text make_string();
        t_text              s;
        t_text              digits;
        logic [VALUE_W-1:0] lim;
        bit                 with_sign;
        bit                 minus;
        int                 kind;
        with_sign = ($urandom_range(0, mode_signed ? 2 : 11) == 0);
        minus     = 1'($urandom_range(0, 1));
        kind      = $urandom_range(0, 99);
        repeat ($urandom_range(0, 3)) s.push_back(CH_BLANK);
        if (with_sign) begin
            s.push_back(minus ? CH_MINUS : CH_PLUS);
            repeat ($urandom_range(0, 2)) s.push_back(CH_BLANK);
        end
        if (kind < 55) begin
            repeat ($urandom_range(0, mode_wide ? 17 : 9))
                s.push_back(digit_char(DIGIT_W'($urandom_range(0, 15))));
        end else begin
            if (kind < 85) begin
                lim = mode_wide ? '1 : 64'h0000_0000_FFFF_FFFF;
                if (mode_signed)
                    lim = (with_sign && minus) ? (lim >> 1) + 1 : (lim >> 1);
                digits = hex_digits(lim - 3 + $urandom_range(0, 6));
            end else begin
                digits = hex_digits(VALUE_W'($urandom_range(0, 4095)));
            end
            foreach (digits[i])
                s.push_back(digits[i]);
        end
        repeat ($urandom_range(0, 3)) s.push_back(CH_BLANK);
        // occasional stray character anywhere in the string
        if ($urandom_range(0, 9) == 0)
            s.insert($urandom_range(0, s.size()), CHAR_W'($urandom_range(0, 255)));
        return s;
    endfunction

    function automatic t_text make_noise();
        t_text s;
        repeat ($urandom_range(1, 6)) s.push_back(CHAR_W'($urandom_range(0, 255)));
        return s;
    endfunction

    initial begin
        int goal;
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.char_code  = '0;
        in_ch.end_marker = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = 1'b0;
        chars_sent       = 0;
        quiet_tail       = 1'b0;
        hold_results     = 1'b0;
        mode_signed      = 1'b1;
        mode_wide        = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty, blank, lone sign, negative zero, mixed case
        send_text("");
        send_text(" ");
        send_text("-");
        send_text("-0");
        send_text("fF");
        // top character code, then a digit that must not clear the error
        send_item(8'hFF, 1'b0);
        send_text("1");
        // nul without end marker
        send_item(8'h00, 1'b0);
        send_text("");
        // digit after trailing blank
        send_text("1 2");
        // write to an index beyond the list leaves the string alone
        send_chars({CH_ZERO + 8'd1}, 1'b0);
        wait_idle();
        write_reg({CFG_IDX_W{1'b1}}, 1'b1);
        send_text("2");
        // sign in unsigned mode
        wait_idle();
        set_modes(1'b0, 1'b0);
        send_text("+1");
        // register write drops the string in progress
        send_chars({CH_ZERO + 8'd5}, 1'b0);
        wait_idle();
        write_reg(CFG_WIDE_MODE, 1'b0);
        send_text("");

        // random phases: all four settings first, then random ones
        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            if ($urandom_range(0, 1))
                write_reg(CFG_IDX_W'($urandom_range(CFG_WIDE_MODE + 1, {CFG_IDX_W{1'b1}})),
                          1'($urandom_range(0, 1)));
            if (p < 4)
                set_modes(p[1], p[0]);
            else
                set_modes(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            if (p == PHASES - 1)
                quiet_tail = 1'b1;
            if (p == 2)
                hold_results = 1'b1;
            goal = chars_sent + CHARS_PER_PHASE;
            while (chars_sent < goal) begin
                if ($urandom_range(0, 9) == 0)
                    send_chars(make_noise(), 1'b1);
                else
                    send_chars(make_string(), 1'b1);
            end
            // leave a string unfinished for the next register write to drop
            if (p != PHASES - 1 && $urandom_range(0, 1))
                send_chars(make_string(), 1'b0);
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("** hex_text_to_integer_top: PASSED **");
        end else begin
            $display("** hex_text_to_integer_top: FAILED **");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/hexint_pkg.sv
sv/hexint_if.sv
sv/hexint_front.sv
sv/hexint_fifo.sv
sv/hexint_back.sv
sv/hex_text_to_integer_top.sv
sim/hex_text_to_integer_checker.sv
sim/hex_text_to_integer_top_tb.sv
